/* hdl/pbc_pkg.sv */
// Shared types, codes and reset constants for the playout buffer controller.
`timescale 1ns / 1ps
package pbc_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 64;

   // Item function codes
   localparam logic [1:0] FUNC_ARRIVAL = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_START   = 2'd2;

   // Player modes
   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_BUFFERING = 2'd1;
   localparam logic [1:0] MODE_PLAYING   = 2'd2;
   localparam logic [1:0] MODE_PAUSED    = 2'd3;

   // Register indexes on the write port
   localparam logic [1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [1:0] CSR_START_DELAY  = 2'd1;
   localparam logic [1:0] CSR_FRAME_PERIOD = 2'd2;

   localparam logic [23:0] CAPACITY_RESET     = 24'd1048576;
   localparam logic [15:0] START_DELAY_RESET  = 16'd1000;
   localparam logic [15:0] FRAME_PERIOD_RESET = 16'd20;
   localparam logic [31:0] RATE_MIN_RESET     = 32'd100000000;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load_item;   // capture the word, read the head descriptor
      logic event_step;  // run the pending play event if it is due
      logic arrive_step; // item action: admission, push, start command
      logic resume_step; // play at now after an arrival ends a pause
      logic load_rsp;    // copy results into the output register
   } cmd_type;

   // Datapath status to the sequencer
   typedef struct packed {
      logic resume_req;
   } status_type;

endpackage

/* hdl/pbc_controller.sv */
// Sequencer for the playout buffer controller: item phases and result handshake.
`timescale 1ns / 1ps
module pbc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pbc_pkg::cmd_type    cmd,
   input  pbc_pkg::status_type status
);
   import pbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVENT,
      ST_ARRIVE,
      ST_RESUME,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.load_item   = (state_ff == ST_IDLE) && req_valid;
      cmd.event_step  = (state_ff == ST_EVENT);
      cmd.arrive_step = (state_ff == ST_ARRIVE);
      cmd.resume_step = (state_ff == ST_RESUME);
      cmd.load_rsp    = (state_ff == ST_LOAD) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EVENT;
               end
            end
            ST_EVENT: begin
               state_ff <= ST_ARRIVE;
            end
            ST_ARRIVE: begin
               state_ff <= status.resume_req ? ST_RESUME : ST_LOAD;
            end
            ST_RESUME: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               // hold until the output register is free
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hdl/pbc_datapath.sv */
// Datapath for the playout buffer controller: descriptor FIFO, play unit, statistics.
`timescale 1ns / 1ps
module pbc_datapath #(
   parameter int FIFO_DEPTH = pbc_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  pbc_pkg::cmd_type    cmd,
   output pbc_pkg::status_type status,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_wdata,
   input  logic [1:0]          req_func,
   input  logic [31:0]         req_now_ms,
   input  logic [23:0]         req_frame_bytes,
   input  logic [31:0]         req_frame_rate_bps,
   input  logic [15:0]         req_segment_id,
   output logic                rsp_accepted,
   output logic                rsp_played,
   output logic [1:0]          rsp_player_state,
   output logic [23:0]         rsp_buffered_bytes,
   output logic [15:0]         rsp_interruption_count,
   output logic [31:0]         rsp_played_count,
   output logic [31:0]         rsp_min_rate_later,
   output logic [31:0]         rsp_min_rate_all,
   output logic [31:0]         rsp_max_rate,
   output logic [63:0]         rsp_rate_sum,
   output logic [31:0]         rsp_startup_delay_ms,
   output logic [31:0]         rsp_paused_total_ms
);
   import pbc_pkg::*;

   localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int DESC_W = 24 + 32 + 1;

   // Configuration
   logic [23:0] capacity_ff;
   logic [15:0] start_delay_ff;
   logic [15:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RESET;
         start_delay_ff <= START_DELAY_RESET;
         period_ff      <= FRAME_PERIOD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAPACITY:     capacity_ff    <= csr_wdata;
            CSR_START_DELAY:  start_delay_ff <= csr_wdata[15:0];
            CSR_FRAME_PERIOD: period_ff      <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Captured item
   logic [1:0]  func_ff;
   logic [31:0] now_ff;
   logic [23:0] fbytes_ff;
   logic [31:0] frate_ff;
   logic        fnfs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff   <= req_func;
         now_ff    <= req_now_ms;
         fbytes_ff <= req_frame_bytes;
         frate_ff  <= req_frame_rate_bps;
         fnfs_ff   <= (req_segment_id != 16'd0);
      end
   end

   // Descriptor memory: {size, rate, not-first-segment}
   logic [DESC_W-1:0] desc_mem_ff [FIFO_DEPTH];
   logic [DESC_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  read_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SUM_W-1:0]  wr_sum;
   logic [PTR_W-1:0]  wr_ptr;
   logic              admit;
   logic              push;

   assign wr_sum = SUM_W'(read_ptr_ff) + SUM_W'(count_ff);
   assign wr_ptr = (wr_sum >= SUM_W'(FIFO_DEPTH)) ?
                   PTR_W'(wr_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(wr_sum);

   always_ff @(posedge clock) begin
      if (push) begin
         desc_mem_ff[wr_ptr] <= {fbytes_ff, frate_ff, fnfs_ff};
      end
      if (cmd.load_item) begin
         rd_data_ff <= desc_mem_ff[read_ptr_ff];
      end
   end

   // Player state and statistics
   logic [1:0]  mode_ff;
   logic [23:0] bytes_held_ff;
   logic        pending_ff;
   logic [31:0] deadline_ff;
   logic        first_play_done_ff;
   logic [31:0] first_buffer_time_ff;
   logic [31:0] pause_start_ff;
   logic [31:0] paused_total_ff;
   logic [15:0] pause_count_ff;
   logic [31:0] play_count_ff;
   logic [31:0] rate_min_later_ff;
   logic [31:0] rate_min_all_ff;
   logic [31:0] rate_max_ff;
   logic [63:0] rate_total_ff;
   logic [31:0] startup_delay_ff;
   logic        accepted_ff;
   logic        played_ff;
   logic        head_new_ff;

   // Play unit
   logic [31:0] play_t;
   logic [31:0] since_deadline;
   logic        due;
   logic        do_play;
   logic        fifo_empty;
   logic [23:0] head_size;
   logic [31:0] head_rate;
   logic        head_nfs;
   logic [64:0] rate_total_in;
   logic [PTR_W-1:0] read_ptr_in;

   // Arrival
   logic [24:0] admit_sum;
   logic [31:0] pause_span;
   logic [32:0] paused_sum;

   assign play_t         = cmd.resume_step ? now_ff : deadline_ff;
   assign since_deadline = now_ff - deadline_ff;
   assign due            = pending_ff && !since_deadline[31];
   assign do_play        = (cmd.event_step && due) || cmd.resume_step;
   assign fifo_empty     = (count_ff == '0);

   always_comb begin
      if (cmd.resume_step && head_new_ff) begin
         head_size = fbytes_ff;
         head_rate = frate_ff;
         head_nfs  = fnfs_ff;
      end else begin
         {head_size, head_rate, head_nfs} = rd_data_ff;
      end
   end

   assign rate_total_in = {1'b0, rate_total_ff} + {33'd0, head_rate};
   assign read_ptr_in   = (read_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                          read_ptr_ff + PTR_W'(1);

   assign admit_sum  = {1'b0, bytes_held_ff} + {1'b0, fbytes_ff};
   assign admit      = (func_ff == FUNC_ARRIVAL) && (admit_sum <= {1'b0, capacity_ff}) &&
                       (count_ff != CNT_W'(FIFO_DEPTH));
   assign push       = cmd.arrive_step && admit;
   assign pause_span = now_ff - pause_start_ff;
   assign paused_sum = {1'b0, paused_total_ff} + {1'b0, pause_span};

   // an admitted arrival while paused plays at now in the next phase
   assign status.resume_req = push && (mode_ff == MODE_PAUSED);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= MODE_IDLE;
         read_ptr_ff          <= '0;
         count_ff             <= '0;
         bytes_held_ff        <= '0;
         pending_ff           <= 1'b0;
         deadline_ff          <= '0;
         first_play_done_ff   <= 1'b0;
         first_buffer_time_ff <= '0;
         pause_start_ff       <= '0;
         paused_total_ff      <= '0;
         pause_count_ff       <= '0;
         play_count_ff        <= '0;
         rate_min_later_ff    <= RATE_MIN_RESET;
         rate_min_all_ff      <= RATE_MIN_RESET;
         rate_max_ff          <= '0;
         rate_total_ff        <= '0;
         startup_delay_ff     <= '0;
         accepted_ff          <= 1'b0;
         played_ff            <= 1'b0;
         head_new_ff          <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            accepted_ff <= 1'b0;
            played_ff   <= 1'b0;
            head_new_ff <= 1'b0;
         end

         if (do_play) begin
            if (mode_ff == MODE_BUFFERING && !first_play_done_ff) begin
               startup_delay_ff   <= play_t - first_buffer_time_ff;
               first_play_done_ff <= 1'b1;
            end
            if (fifo_empty) begin
               // underrun: pause and schedule nothing
               mode_ff        <= MODE_PAUSED;
               pause_start_ff <= play_t;
               if (cmd.event_step) begin
                  pending_ff <= 1'b0;
               end
               if (pause_count_ff != 16'hFFFF) begin
                  pause_count_ff <= pause_count_ff + 16'd1;
               end
            end else begin
               if (mode_ff == MODE_BUFFERING) begin
                  mode_ff <= MODE_PLAYING;
               end
               bytes_held_ff <= bytes_held_ff - head_size;
               if (head_nfs && head_rate < rate_min_later_ff) begin
                  rate_min_later_ff <= head_rate;
               end
               read_ptr_ff   <= read_ptr_in;
               count_ff      <= count_ff - CNT_W'(1);
               rate_total_ff <= rate_total_in[64] ? {64{1'b1}} : rate_total_in[63:0];
               if (head_rate < rate_min_all_ff) begin
                  rate_min_all_ff <= head_rate;
               end
               if (head_rate > rate_max_ff) begin
                  rate_max_ff <= head_rate;
               end
               if (play_count_ff != 32'hFFFF_FFFF) begin
                  play_count_ff <= play_count_ff + 32'd1;
               end
               pending_ff  <= 1'b1;
               deadline_ff <= play_t + {16'd0, period_ff};
               played_ff   <= 1'b1;
            end
         end

         if (push) begin
            count_ff      <= count_ff + CNT_W'(1);
            bytes_held_ff <= admit_sum[23:0];
            accepted_ff   <= 1'b1;
            if (mode_ff == MODE_PAUSED) begin
               mode_ff         <= MODE_PLAYING;
               paused_total_ff <= paused_sum[32] ? 32'hFFFF_FFFF : paused_sum[31:0];
               head_new_ff     <= fifo_empty;
            end else if (mode_ff == MODE_IDLE) begin
               mode_ff <= MODE_BUFFERING;
               if (!first_play_done_ff) begin
                  first_buffer_time_ff <= now_ff;
               end
               pending_ff  <= 1'b1;
               deadline_ff <= now_ff + {16'd0, start_delay_ff};
            end
         end else if (cmd.arrive_step && func_ff == FUNC_START) begin
            mode_ff         <= MODE_PLAYING;
            paused_total_ff <= '0;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted           <= accepted_ff;
         rsp_played             <= played_ff;
         rsp_player_state       <= mode_ff;
         rsp_buffered_bytes     <= bytes_held_ff;
         rsp_interruption_count <= pause_count_ff;
         rsp_played_count       <= play_count_ff;
         rsp_min_rate_later     <= rate_min_later_ff;
         rsp_min_rate_all       <= rate_min_all_ff;
         rsp_max_rate           <= rate_max_ff;
         rsp_rate_sum           <= rate_total_ff;
         rsp_startup_delay_ms   <= startup_delay_ff;
         rsp_paused_total_ms    <= paused_total_ff;
      end
   end

endmodule

/* hdl/playout_buffer_controller.sv */
// Top level of the video playout buffer controller.
`timescale 1ns / 1ps
// Video playout buffer controller. Each request word is a frame arrival, a
// time tick or a start command and carries the current time in ms; every
// request yields exactly one response word with the admission and play flags,
// the player state and the running play statistics. A request occupies the
// block from its acceptance to the next acceptance, set by the sequencer's
// phases: capture and descriptor read, pending play event, item action,
// resume play only when an arrival ends an underrun pause, response load.
// The response sits in an output register, so the next request is accepted
// while the previous response still waits; a stalled response holds the
// sequencer only at its final phase. Arrivals are admitted when the held
// bytes plus the frame size fit in the capacity register and the
// FIFO_DEPTH-entry descriptor FIFO has room. Write the registers through
// csr_ only while the block is idle.
module playout_buffer_controller #(
   parameter int FIFO_DEPTH = pbc_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Register write port
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic [23:0] req_frame_bytes,
   input  logic [31:0] req_frame_rate_bps,
   input  logic [15:0] req_segment_id,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_played,
   output logic [1:0]  rsp_player_state,
   output logic [23:0] rsp_buffered_bytes,
   output logic [15:0] rsp_interruption_count,
   output logic [31:0] rsp_played_count,
   output logic [31:0] rsp_min_rate_later,
   output logic [31:0] rsp_min_rate_all,
   output logic [31:0] rsp_max_rate,
   output logic [63:0] rsp_rate_sum,
   output logic [31:0] rsp_startup_delay_ms,
   output logic [31:0] rsp_paused_total_ms
);
   import pbc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: walks each word through its phases and owns rsp_valid
   pbc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: registers, descriptor memory, play unit and response register
   pbc_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_func               (req_func),
      .req_now_ms             (req_now_ms),
      .req_frame_bytes        (req_frame_bytes),
      .req_frame_rate_bps     (req_frame_rate_bps),
      .req_segment_id         (req_segment_id),
      .rsp_accepted           (rsp_accepted),
      .rsp_played             (rsp_played),
      .rsp_player_state       (rsp_player_state),
      .rsp_buffered_bytes     (rsp_buffered_bytes),
      .rsp_interruption_count (rsp_interruption_count),
      .rsp_played_count       (rsp_played_count),
      .rsp_min_rate_later     (rsp_min_rate_later),
      .rsp_min_rate_all       (rsp_min_rate_all),
      .rsp_max_rate           (rsp_max_rate),
      .rsp_rate_sum           (rsp_rate_sum),
      .rsp_startup_delay_ms   (rsp_startup_delay_ms),
      .rsp_paused_total_ms    (rsp_paused_total_ms)
   );

endmodule
